// File: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/ramr_pkg.sv
// Package with the shared types and constants of the rational reduce block.
package ramr_pkg;
    localparam int MagW = 33;
    localparam int DenW = 30;
    localparam logic CmdAdd = 1'b0;
    localparam logic CmdMul = 1'b1;

    typedef struct packed {
        logic          command;
        logic [15:0]   num_a;
        logic [14:0]   den_a;
        logic [15:0]   num_b;
        logic [14:0]   den_b;
    } in_item_t;

    typedef struct packed {
        logic [31:0] res_num;
        logic [29:0] res_den;
        logic        bad_input;
    } out_item_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;
endpackage

// File: sv/ramr_if.sv
// Valid/ready channel interfaces for input and result transactions.
interface ramr_in_if;
    logic             valid;
    logic             ready;
    ramr_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ramr_out_if;
    logic              valid;
    logic              ready;
    ramr_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/rational_add_multiply_reduce_top.sv
// Top level of the rational add/multiply unit with GCD reduction.
// Channel in_ch carries one transaction per operation: command (0 add,
// 1 multiply) and two fractions num_a/den_a and num_b/den_b.
// Channel out_ch returns one transaction per input: the reduced numerator
// res_num, the positive denominator res_den and the bad_input flag.
// The block handles one operation at a time and is not ready while busy.
// Products use one 17 by 17 signed multiplier in states S_M1 to S_M3.
// The GCD runs on one shared 33-bit restoring divider, and the number
// of remainder steps depends on the operands.
// Two more divisions then reduce numerator and denominator.
// A zero denominator or zero numerator gives 0/1 without any division.
// The result is held in an output register until the receiver takes it;
// the next input is taken while that register waits.
// Reset returns the sequencer to idle and empties the output register.
`include "assert_macros.svh"
module rational_add_multiply_reduce_top (
    input logic        clk,
    input logic        rst_n,
    ramr_in_if.sink    in_ch,
    ramr_out_if.source out_ch
);
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_M1   = 9'b000000010,
        S_M2   = 9'b000000100,
        S_M3   = 9'b000001000,
        S_CHK  = 9'b000010000,
        S_GCD  = 9'b000100000,
        S_DVN  = 9'b001000000,
        S_DVD  = 9'b010000000,
        S_OUT  = 9'b100000000
    } state_t;

    localparam int MW = ramr_pkg::MagW;

    state_t state_reg, state_next;
    ramr_pkg::in_item_t  in_reg;
    logic signed [32:0]  n_reg;
    logic [MW-1:0]       y_reg, mag_reg, den_reg, g_reg;
    logic                neg_reg;
    logic [31:0]         rnum_reg;
    logic [29:0]         rden_reg;
    logic                bad_reg;
    logic                ov_reg;
    logic                started_reg;

    logic signed [16:0]  ma, mb;
    logic signed [33:0]  mprod;
    logic                div_start;
    logic [MW-1:0]       div_a, div_b, div_q, div_r;
    ramr_pkg::div_ctl_t  div_ctl;
    logic                fin;
    logic                take;
    logic [MW-1:0]       nmag;

    assign take = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);

    always_comb
    begin
        ma = 17'sd0;
        mb = 17'sd0;
        case (state_reg)
            S_M1:
            begin
                ma = 17'(signed'(in_reg.num_a));
                mb = in_reg.command ? 17'(signed'(in_reg.num_b))
                                    : signed'({2'b0, in_reg.den_b});
            end
            S_M2:
            begin
                ma = 17'(signed'(in_reg.num_b));
                mb = signed'({2'b0, in_reg.den_a});
            end
            S_M3:
            begin
                ma = signed'({2'b0, in_reg.den_a});
                mb = signed'({2'b0, in_reg.den_b});
            end
            default:
            begin
                ma = 17'sd0;
                mb = 17'sd0;
            end
        endcase
    end
    assign mprod = ma * mb;
    assign nmag  = n_reg[32] ? MW'(-n_reg) : MW'(n_reg);

    always_comb
    begin
        div_start = 1'b0;
        div_a     = '0;
        div_b     = y_reg;
        case (state_reg)
            S_CHK:
            begin
                div_start = (n_reg != '0) && !bad_reg;
                div_a     = nmag;
                div_b     = den_reg;
            end
            S_GCD:
            begin
                div_start = div_ctl.done && (div_r != '0);
                div_a     = y_reg;
                div_b     = div_r;
                if (div_ctl.done && (div_r == '0))
                begin
                    div_start = 1'b1;
                    div_a     = mag_reg;
                    div_b     = y_reg;
                end
            end
            S_DVN:
            begin
                div_start = div_ctl.done;
                div_a     = den_reg;
                div_b     = g_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    ramr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .ctl       (div_ctl),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign fin = out_ch.valid && !out_ch.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (take) state_next = S_M1;
            S_M1:   state_next = S_M2;
            S_M2:   state_next = S_M3;
            S_M3:   state_next = S_CHK;
            S_CHK:  state_next = div_start ? S_GCD : S_OUT;
            S_GCD:  if (div_ctl.done && (div_r == '0)) state_next = S_DVN;
            S_DVN:  if (div_ctl.done) state_next = S_DVD;
            S_DVD:  if (div_ctl.done) state_next = S_OUT;
            S_OUT:  if (!fin) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ov_reg      <= 1'b0;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_OUT && !fin)
                ov_reg <= 1'b1;
            else if (out_ch.ready)
                ov_reg <= 1'b0;
            if (take)
                started_reg <= 1'b1;
            else if (state_reg == S_OUT && !fin)
                started_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    in_reg  <= in_ch.data;
                    bad_reg <= (in_ch.data.den_a == '0) || (in_ch.data.den_b == '0);
                end
            end
            S_M1:
            begin
                n_reg <= 33'(mprod);
            end
            S_M2:
            begin
                if (in_reg.command == ramr_pkg::CmdAdd)
                    n_reg <= n_reg + 33'(mprod);
            end
            S_M3:
            begin
                den_reg <= MW'(mprod);
                neg_reg <= n_reg[32];
            end
            S_CHK:
            begin
                mag_reg <= nmag;
                y_reg   <= den_reg;
                if (!div_start)
                begin
                    rnum_reg <= '0;
                    rden_reg <= 30'd1;
                end
            end
            S_GCD:
            begin
                if (div_ctl.done)
                begin
                    if (div_r != '0)
                        y_reg <= div_r;
                    else
                        g_reg <= y_reg;
                end
            end
            S_DVN:
            begin
                if (div_ctl.done)
                    rnum_reg <= neg_reg ? 32'(-div_q) : 32'(div_q);
            end
            S_DVD:
            begin
                if (div_ctl.done)
                    rden_reg <= 30'(div_q);
            end
            default:
            begin
            end
        endcase
        if (state_reg == S_OUT && !fin)
        begin
            out_ch.data.res_num   <= rnum_reg;
            out_ch.data.res_den   <= rden_reg;
            out_ch.data.bad_input <= bad_reg;
        end
    end

    assign out_ch.valid = ov_reg;

    `ASSERT_IMPL(a_busy_not_ready, clk, rst_n, state_reg != S_IDLE, !in_ch.ready)
    `ASSERT_IMPL(a_div_idle_start, clk, rst_n, div_start, !div_ctl.busy || div_ctl.done)
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid)
    `ASSERT_IMPL(a_one_pending, clk, rst_n, state_reg == S_OUT, started_reg)
endmodule

// File: sv/ramr_div.sv
// Shared restoring divider, one quotient bit per cycle.
module ramr_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ramr_pkg::MagW-1:0]  dividend,
    input  logic [ramr_pkg::MagW-1:0]  divisor,
    output ramr_pkg::div_ctl_t         ctl,
    output logic [ramr_pkg::MagW-1:0]  quotient,
    output logic [ramr_pkg::MagW-1:0]  remainder
);
    localparam int CntW = $clog2(ramr_pkg::MagW + 1);

    logic [ramr_pkg::MagW-1:0] q_reg, q_next;
    logic [ramr_pkg::MagW-1:0] r_reg, r_next;
    logic [ramr_pkg::MagW-1:0] d_reg, d_next;
    logic [CntW-1:0]           cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [ramr_pkg::MagW:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[ramr_pkg::MagW-1]} - {1'b0, d_reg};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = CntW'(ramr_pkg::MagW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[ramr_pkg::MagW])
            begin
                r_next = {r_reg[ramr_pkg::MagW-2:0], q_reg[ramr_pkg::MagW-1]};
                q_next = {q_reg[ramr_pkg::MagW-2:0], 1'b0};
            end
            else
            begin
                r_next = trial[ramr_pkg::MagW-1:0];
                q_next = {q_reg[ramr_pkg::MagW-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign ctl       = '{start: start, busy: busy_reg, done: done_reg};
    assign quotient  = q_reg;
    assign remainder = r_reg;
endmodule

// File: verif/ramr_tb_if.sv
`timescale 1ns / 100ps
// Package with the stall limits used by the testbench.
package ramr_tb_pkg;
    localparam int StallShortMax = 3;
    localparam int StallLongMax = 60;
endpackage

// File: verif/rational_add_multiply_reduce_top_tb.sv
`timescale 1ns / 100ps
// Testbench of the rational add/multiply unit: predicts and checks reduced fractions.
module rational_add_multiply_reduce_top_tb;

    class fraction_scoreboard;
        ramr_pkg::out_item_t pending_q[$];
        int errors;

        function longint unsigned euclid(longint unsigned x, longint unsigned y);
            longint unsigned r;
            while (y != 0)
            begin
                r = x % y;
                x = y;
                y = r;
            end
            return x;
        endfunction

        function void note_input(ramr_pkg::in_item_t it);
            ramr_pkg::out_item_t o;
            longint sa;
            longint sb;
            longint n;
            longint unsigned den;
            longint unsigned mag;
            longint unsigned g;
            sa = longint'($signed(it.num_a));
            sb = longint'($signed(it.num_b));
            o.res_num = '0;
            o.res_den = 30'd1;
            o.bad_input = 1'b0;
            if (it.den_a == 0 || it.den_b == 0)
            begin
                o.bad_input = 1'b1;
            end
            else
            begin
                if (it.command == ramr_pkg::CmdAdd)
                    n = sa * it.den_b + sb * it.den_a;
                else
                    n = sa * sb;
                den = longint'(it.den_a) * it.den_b;
                if (n != 0)
                begin
                    mag = (n < 0) ? -n : n;
                    g = euclid(mag, den);
                    mag = mag / g;
                    den = den / g;
                    o.res_num = (n < 0) ? 32'(-mag) : 32'(mag);
                    o.res_den = 30'(den);
                end
            end
            pending_q.push_back(o);
        endfunction

        function void check_result(ramr_pkg::out_item_t got);
            ramr_pkg::out_item_t exp;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp = pending_q.pop_front();
            if (got.res_num !== exp.res_num)
            begin
                $display("%0t: res_num expected %0d actual %0d", $time,
                         $signed(exp.res_num), $signed(got.res_num));
                errors++;
            end
            if (got.res_den !== exp.res_den)
            begin
                $display("%0t: res_den expected %0d actual %0d", $time,
                         exp.res_den, got.res_den);
                errors++;
            end
            if (got.bad_input !== exp.bad_input)
            begin
                $display("%0t: bad_input expected %0b actual %0b", $time,
                         exp.bad_input, got.bad_input);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    ramr_in_if in_ch();
    ramr_out_if out_ch();
    fraction_scoreboard fraction_sb;
    bit stimulus_done;

    rational_add_multiply_reduce_top uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    function automatic int gap_length();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40)
            return 0;
        if (p < 93)
            return $urandom_range(1, ramr_tb_pkg::StallShortMax);
        return $urandom_range(ramr_tb_pkg::StallShortMax + 1, ramr_tb_pkg::StallLongMax);
    endfunction

    task automatic send_fraction_op(ramr_pkg::in_item_t it);
        int g;
        g = gap_length();
        if (g != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        fraction_sb.note_input(it);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (fraction_sb.pending_q.size() != 0) @(posedge clk);
    endtask

    function automatic logic [14:0] pick_den();
        int p;
        p = $urandom_range(0, 99);
        if (p < 4)
            return '0;
        if (p < 30)
            return 15'($urandom_range(1, 16));
        if (p < 40)
            return 15'(15'h7fff - $urandom_range(0, 3));
        return 15'($urandom_range(1, 32767));
    endfunction

    function automatic logic [15:0] pick_num();
        int p;
        p = $urandom_range(0, 99);
        if (p < 5)
            return '0;
        if (p < 30)
            return 16'($signed($urandom_range(0, 40)) - 20);
        if (p < 40)
            return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic send_op(logic cmd, logic [15:0] na, logic [14:0] da,
                           logic [15:0] nb, logic [14:0] db);
        ramr_pkg::in_item_t it;
        it.command = cmd;
        it.num_a = na;
        it.den_a = da;
        it.num_b = nb;
        it.den_b = db;
        send_fraction_op(it);
    endtask

    initial
    begin
        int k;
        ramr_pkg::in_item_t it;
        fraction_sb = new();
        stimulus_done = 0;
        rst_n = 0;
        in_ch.valid = 0;
        in_ch.data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        send_op(ramr_pkg::CmdAdd, 16'h7fff, 15'h7fff, 16'h7fff, 15'h7fff);
        send_op(ramr_pkg::CmdMul, 16'h8000, 15'h7fff, 16'h8000, 15'h7fff);
        send_op(ramr_pkg::CmdAdd, 16'h8000, 15'd1, 16'h8000, 15'd1);
        send_op(ramr_pkg::CmdMul, 16'h8000, 15'd1, 16'h7fff, 15'd1);
        send_op(ramr_pkg::CmdAdd, 16'd1, 15'd2, 16'hffff, 15'd2);
        send_op(ramr_pkg::CmdMul, 16'd0, 15'd5, 16'd7, 15'd3);
        send_op(ramr_pkg::CmdAdd, 16'd3, 15'd0, 16'd1, 15'd1);
        send_op(ramr_pkg::CmdMul, 16'd3, 15'd4, 16'd1, 15'd0);
        send_op(ramr_pkg::CmdAdd, 16'd0, 15'd0, 16'd0, 15'd0);
        send_op(ramr_pkg::CmdAdd, 16'hfffd, 15'd6, 16'hfffe, 15'd4);
        send_op(ramr_pkg::CmdMul, 16'hfffd, 15'd6, 16'd4, 15'd9);
        send_op(ramr_pkg::CmdAdd, 16'd1, 15'h7fff, 16'd1, 15'h7ffe);
        send_op(ramr_pkg::CmdMul, 16'h5555, 15'h2aaa, 16'haaaa, 15'h5555);
        send_op(ramr_pkg::CmdAdd, 16'd0, 15'd1, 16'd0, 15'd1);
        drain_results();
        for (k = 0; k < 1300; k++)
        begin
            it.command = 1'($urandom_range(0, 1));
            it.num_a = pick_num();
            it.den_a = pick_den();
            it.num_b = pick_num();
            it.den_b = pick_den();
            send_fraction_op(it);
            if (k == 650)
                drain_results();
        end
        in_ch.valid <= 1'b0;
        stimulus_done = 1;
    end

    initial
    begin
        int hold_cnt;
        hold_cnt = 0;
        out_ch.ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                fraction_sb.check_result(out_ch.data);
            if (hold_cnt > 0)
                hold_cnt--;
            else
                hold_cnt = gap_length();
            out_ch.ready <= (hold_cnt == 0);
        end
    end

    initial
    begin
        wait (stimulus_done);
        while (fraction_sb.pending_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (fraction_sb.errors == 0 && fraction_sb.pending_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule
